// File: rtl/wnm_pkg.sv
// ----------------------------------------------------------------------------
// wnm_pkg: shared types and constants of the wildcard name matcher
// Character codes, register indexes and the structures that pass between
// the configuration block, the matching core and the top level.
// ----------------------------------------------------------------------------
package wnm_pkg;

   localparam int CharW     = 8;
   localparam int CsrIndexW = 2;
   localparam int CsrDataW  = 64;
   localparam int PatCharsW = 128;
   localparam int PatLenW   = 5;

   localparam logic [CharW-1:0] StarChar  = 8'h2A;
   localparam logic [CharW-1:0] QueryChar = 8'h3F;
   localparam logic [CharW-1:0] PctChar   = 8'h25;
   localparam logic [CharW-1:0] SpaceChar = 8'h20;

   localparam logic [CsrIndexW-1:0] CsrPatternLow  = 2'd0;
   localparam logic [CsrIndexW-1:0] CsrPatternHigh = 2'd1;
   localparam logic [CsrIndexW-1:0] CsrPatternLen  = 2'd2;

   // Pattern as held in the configuration registers.
   typedef struct packed {
      logic [PatCharsW-1:0] chars;
      logic [PatLenW-1:0]   length;
   } pattern_type;

   // One name character handed from the input register to the core.
   typedef struct packed {
      logic             fire;
      logic             last;
      logic [CharW-1:0] name_char;
   } step_type;

endpackage

// File: rtl/wildcard_name_matcher.sv
// ----------------------------------------------------------------------------
// wildcard_name_matcher: streamed name against a wildcard pattern
// Matches a space-padded name, one character per request, against a
// pattern of up to sixteen characters with '*', '?' and '%' wildcards.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   -------   ---------  -------------------  ---------------------------------
//   req_      in         req_valid/req_stall  req_name_char, req_last_char
//   rsp_      out        rsp_valid/rsp_stall  rsp_matched
//   csr_      in         csr_valid/csr_ready  csr_index, csr_data
//
// One request is taken every clock cycle while req_stall is low. A request
// is registered on acceptance and is folded into the automaton when it leaves
// the input register; a request flagged as the last character then places its
// match flag in the result register as it is folded in.
// The critical path is the two star-closure chains across the pattern
// positions in the automaton update.
// Reset is synchronous and active high; it clears the pattern to empty and
// returns the automaton to position zero.
// A stalled result holds only last-character requests back: other
// characters keep flowing into the automaton while the result waits.
//
module wildcard_name_matcher #(
   parameter int MAX_PATTERN = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_name_char,
   input  logic                                 req_last_char,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_matched,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [wnm_pkg::CsrIndexW-1:0]        csr_index,
   input  logic [wnm_pkg::CsrDataW-1:0]         csr_data
);

   // Input register: one request waiting for the automaton.
   logic                      s1_valid_ff, s1_valid_in;
   logic                      s1_last_ff, s1_last_in;
   logic [wnm_pkg::CharW-1:0] s1_char_ff, s1_char_in;

   // Result register.
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_matched_ff, rsp_matched_in;

   logic                 req_take;
   logic                 s1_move;
   logic                 core_matched;
   wnm_pkg::step_type    step;
   wnm_pkg::pattern_type pattern;

   // The configuration registers take a write in every cycle.
   assign csr_ready = 1'b1;

   wnm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .pattern   (pattern)
   );

   // The held request moves on unless it needs the result register and
   // that register is still occupied by a result that is stalled.
   assign s1_move   = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_move;
   assign req_take  = req_valid && !req_stall;

   assign step.fire      = s1_move;
   assign step.last      = s1_last_ff;
   assign step.name_char = s1_char_ff;

   wnm_core #(
      .MaxPattern (MAX_PATTERN)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .pattern (pattern),
      .matched (core_matched)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_last_in  = s1_last_ff;
      s1_char_in  = s1_char_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_last_in  = req_last_char;
         s1_char_in  = req_name_char;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_matched_in = rsp_matched_ff;
      if (s1_move && s1_last_ff) begin
         rsp_valid_in   = 1'b1;
         rsp_matched_in = core_matched;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      s1_last_ff     <= s1_last_in;
      s1_char_ff     <= s1_char_in;
      rsp_matched_ff <= rsp_matched_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_matched = rsp_matched_ff;

endmodule

// File: rtl/wnm_csr.sv
// ----------------------------------------------------------------------------
// wnm_csr: pattern configuration registers
// Holds the sixteen pattern characters and the pattern length.
// ----------------------------------------------------------------------------
module wnm_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   input  logic [wnm_pkg::CsrIndexW-1:0]  csr_index,
   input  logic [wnm_pkg::CsrDataW-1:0]   csr_data,
   output wnm_pkg::pattern_type           pattern
);

   logic [wnm_pkg::CsrDataW-1:0] low_ff, low_in;
   logic [wnm_pkg::CsrDataW-1:0] high_ff, high_in;
   logic [wnm_pkg::PatLenW-1:0]  len_ff, len_in;

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      len_in  = len_ff;
      if (csr_valid) begin
         case (csr_index)
            wnm_pkg::CsrPatternLow:  low_in  = csr_data;
            wnm_pkg::CsrPatternHigh: high_in = csr_data;
            wnm_pkg::CsrPatternLen:  len_in  = csr_data[wnm_pkg::PatLenW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= '0;
         high_ff <= '0;
         len_ff  <= '0;
      end else begin
         low_ff  <= low_in;
         high_ff <= high_in;
         len_ff  <= len_in;
      end
   end

   assign pattern.chars  = {high_ff, low_ff};
   assign pattern.length = len_ff;

endmodule

// File: rtl/wnm_core.sv
// ----------------------------------------------------------------------------
// wnm_core: bit-parallel wildcard automaton
// Keeps the set of reached pattern positions and the end-of-name flag, and
// updates every position at once for each name character.
// ----------------------------------------------------------------------------
module wnm_core #(
   parameter int MaxPattern = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  wnm_pkg::step_type    step,
   input  wnm_pkg::pattern_type pattern,
   output logic                 matched
);

   localparam int StateW = MaxPattern + 1;
   localparam int LenW   = $clog2(MaxPattern + 1);

   logic [StateW-1:0]     active_ff, active_in;
   logic                  ended_ff, ended_in;
   logic [LenW-1:0]       len;
   logic [MaxPattern-1:0] in_use, star_live, one_live;
   logic [StateW-1:0]     closed_now, advanced, closed_next, after;
   logic                  do_advance;

   // A '*' lets a reached position pass on to the next one with no character.
   function automatic logic [StateW-1:0] closure(input logic [StateW-1:0]     set,
                                                 input logic [MaxPattern-1:0] stars);
      logic [StateW-1:0] r;
      r = set;
      for (int i = 0; i < MaxPattern; i++) begin
         if (r[i] && stars[i]) r[i+1] = 1'b1;
      end
      return r;
   endfunction

   function automatic logic [StateW-1:0] advance(input logic [StateW-1:0]     set,
                                                 input logic [MaxPattern-1:0] stars,
                                                 input logic [MaxPattern-1:0] ones);
      logic [StateW-1:0] r;
      r = '0;
      for (int i = 0; i < MaxPattern; i++) begin
         if (set[i] && stars[i]) r[i] = 1'b1;
         else if (set[i] && ones[i]) r[i+1] = 1'b1;
      end
      return r;
   endfunction

   assign len = (pattern.length > wnm_pkg::PatLenW'(MaxPattern)) ?
                LenW'(MaxPattern) : LenW'(pattern.length);

   for (genvar g = 0; g < MaxPattern; g++) begin : g_pos
      logic [wnm_pkg::CharW-1:0] pc;
      assign pc           = pattern.chars[wnm_pkg::CharW*g +: wnm_pkg::CharW];
      assign in_use[g]    = LenW'(g) < len;
      assign star_live[g] = in_use[g] && (pc == wnm_pkg::StarChar);
      assign one_live[g]  = in_use[g] && (pc != wnm_pkg::StarChar) &&
                            ((pc == wnm_pkg::QueryChar) || (pc == wnm_pkg::PctChar) ||
                             (pc == step.name_char));
   end

   assign do_advance  = !ended_ff && (step.name_char != wnm_pkg::SpaceChar);
   assign closed_now  = closure(active_ff, star_live);
   assign advanced    = advance(closed_now, star_live, one_live);
   assign closed_next = closure(advanced, star_live);
   assign after       = do_advance ? closed_next : closed_now;
   assign matched     = after[len];

   always_comb begin
      active_in = active_ff;
      ended_in  = ended_ff;
      if (step.fire) begin
         if (step.last) begin
            active_in = StateW'(1);
            ended_in  = 1'b0;
         end else if (do_advance) begin
            active_in = closed_next;
         end else begin
            ended_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= StateW'(1);
         ended_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         ended_ff  <= ended_in;
      end
   end

endmodule

// File: rtl/wnm_checker.sv
// ----------------------------------------------------------------------------
// wnm_checker: port-level checks of the wildcard name matcher
// Watches the request and result channels and checks ordering, occupancy
// and stall behaviour over time.
// ----------------------------------------------------------------------------
module wnm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_last_char,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_matched
);

   // Last-character requests taken whose results have not yet been delivered.
   logic [1:0] pending_ff, pending_in;
   logic       req_last_take;
   logic       rsp_take;

   assign req_last_take = req_valid && !req_stall && req_last_char;
   assign rsp_take      = rsp_valid && !rsp_stall;

   always_comb begin
      pending_in = pending_ff;
      if (req_last_take && !rsp_take) pending_in = pending_ff + 2'd1;
      else if (!req_last_take && rsp_take) pending_in = pending_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // Every result belongs to an earlier last-character request.
   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> (pending_ff != 2'd0))
      else $error("result delivered with no last-character request outstanding");

   // At most one result waits in the input register and one in the output.
   a_bounded_pending: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more last-character requests outstanding than the block can hold");

   // Requests are held back only behind a stalled result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled while the result channel is free");

   // A stalled result keeps its flag.
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_matched)))
      else $error("stalled result dropped or changed");

   // Reset empties the result register.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result still valid after reset");

endmodule

bind wildcard_name_matcher wnm_checker u_checker (.*);
